>>> rtl/scf_pkg.sv
package scf_pkg;

  // Default sizes of the frame buffer and the byte queue.
  localparam int FRAME_BYTES_DEF = 10;
  localparam int QUEUE_DEPTH_DEF = 10;

  // Only the first four frame bytes are ever examined at dispatch.
  localparam int HEAD_BYTES   = 4;
  localparam int MOVE_MIN_LEN = 4;

  // Framing and command characters.
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_BANG    = 8'h21;
  localparam logic [7:0] CH_MOVE    = 8'h6A;
  localparam logic [7:0] CH_LEGACY  = 8'h6D;

  localparam logic [7:0] LIMIT_RESET = 8'd25;

  // Operation codes of an input transaction.
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_POP  = 1'b1;

  // Result status codes.
  localparam logic [2:0] ST_MOVE    = 3'd0;
  localparam logic [2:0] ST_QUEUED  = 3'd1;
  localparam logic [2:0] ST_SHORT   = 3'd2;
  localparam logic [2:0] ST_UNKNOWN = 3'd3;
  localparam logic [2:0] ST_FULL    = 3'd4;
  localparam logic [2:0] ST_POPPED  = 3'd5;
  localparam logic [2:0] ST_EMPTY   = 3'd6;

  // One result as it travels through the pipeline.
  typedef struct packed {
    logic [2:0] status;
    logic [7:0] axis_x;
    logic [7:0] axis_y;
    logic [7:0] axis_z;
    logic [7:0] data_byte;
    logic       use_ram;
    logic       legacy_mode;
    logic       queue_not_empty;
  } res_t;

endpackage

>>> rtl/scf_ram.sv
module scf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 10,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Single write port, registered read that holds when not enabled.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/serial_command_framer_with_fifo.sv
// Channel | Direction | Handshake          | Payload
// in      | input     | in_valid/in_stall   | in_operation, in_rx_byte
// out     | output    | out_valid/out_stall | status, axes, data byte, mode, queue flag
// cfg     | input     | cfg_valid/cfg_ready | cfg_move_limit
//
// One transaction is accepted per cycle while in_stall is low; a result, where
// one is due, goes through the first result register and then the output
// register. The first result register waits on the registered read of the
// queue RAM for a pop, and the output register merges the popped byte.
// Synchronous active-low reset clears the frame fill, the queue pointers and
// count, the mode flag, both result valid flags and the limit (to 25); the RAM
// needs no clearing pass. A stalled output backs up into in_stall once both result registers are full.
module serial_command_framer_with_fifo #(
  parameter int FRAME_BYTES = scf_pkg::FRAME_BYTES_DEF,
  parameter int QUEUE_DEPTH = scf_pkg::QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_operation,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] out_status,
  output logic [7:0] out_axis_x,
  output logic [7:0] out_axis_y,
  output logic [7:0] out_axis_z,
  output logic [7:0] out_data_byte,
  output logic       out_legacy_mode,
  output logic       out_queue_not_empty,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_move_limit
);

  import scf_pkg::*;

  localparam int FILL_W = $clog2(FRAME_BYTES + 1);
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  localparam logic [FILL_W-1:0] FILL_LAST = FILL_W'(FRAME_BYTES - 1);
  localparam logic [FILL_W-1:0] FILL_MOVE = FILL_W'(MOVE_MIN_LEN - 1);
  localparam logic [CNT_W-1:0]  CNT_FULL  = CNT_W'(QUEUE_DEPTH);
  localparam logic [PTR_W-1:0]  PTR_LAST  = PTR_W'(QUEUE_DEPTH - 1);

  logic [7:0]        move_limit_r;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [7:0]        head_r [HEAD_BYTES];
  logic [PTR_W-1:0]  rptr_r, rptr_nxt;
  logic [PTR_W-1:0]  wptr_r, wptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              mode_r, mode_nxt;

  logic              s1_valid_r;
  res_t              s1_res_r;
  logic              out_valid_r;
  res_t              out_res_r;

  logic              in_acc;
  logic              s1_move;
  logic              gen;
  logic              push;
  logic              pop_hit;
  res_t              res;
  logic [7:0]        fb [HEAD_BYTES];
  logic [7:0]        ram_rdata;

  // Configuration is always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      move_limit_r <= LIMIT_RESET;
    end else if (cfg_valid) begin
      move_limit_r <= cfg_move_limit;
    end
  end

  // Pipeline flow: the first result register advances whenever the output is free.
  assign s1_move  = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !s1_move;
  assign in_acc   = in_valid && !in_stall;

  // View of the frame head including the byte arriving now.
  always_comb begin
    for (int i = 0; i < HEAD_BYTES; i++) begin
      fb[i] = (fill_r == FILL_W'(i)) ? in_rx_byte : head_r[i];
    end
  end

  // Decode the transaction and compute the next state and the result.
  always_comb begin
    fill_nxt  = fill_r;
    rptr_nxt  = rptr_r;
    wptr_nxt  = wptr_r;
    count_nxt = count_r;
    mode_nxt  = mode_r;
    gen       = 1'b0;
    push      = 1'b0;
    pop_hit   = 1'b0;
    res       = '0;
    if (in_operation == OP_POP) begin
      gen = 1'b1;
      if (count_r == '0) begin
        res.status = ST_EMPTY;
      end else begin
        pop_hit     = 1'b1;
        res.status  = ST_POPPED;
        res.use_ram = 1'b1;
        rptr_nxt    = (rptr_r == PTR_LAST) ? '0 : rptr_r + 1'b1;
        count_nxt   = count_r - 1'b1;
      end
    end else begin
      fill_nxt = fill_r + 1'b1;
      if (in_rx_byte == CH_NEWLINE || in_rx_byte == CH_BANG || fill_r == FILL_LAST) begin
        gen      = 1'b1;
        fill_nxt = '0;
        if (fb[0] == CH_LEGACY) begin
          mode_nxt      = 1'b1;
          res.data_byte = fb[1];
          if (count_r == CNT_FULL) begin
            res.status = ST_FULL;
          end else begin
            push       = 1'b1;
            res.status = ST_QUEUED;
            wptr_nxt   = (wptr_r == PTR_LAST) ? '0 : wptr_r + 1'b1;
            count_nxt  = count_r + 1'b1;
          end
        end else if (fb[0] == CH_MOVE) begin
          mode_nxt = 1'b0;
          if (fill_r >= FILL_MOVE) begin
            res.status = ST_MOVE;
            res.axis_x = (fb[1] > move_limit_r) ? move_limit_r : fb[1];
            res.axis_y = (fb[2] > move_limit_r) ? move_limit_r : fb[2];
            res.axis_z = (fb[3] > move_limit_r) ? move_limit_r : fb[3];
          end else begin
            res.status = ST_SHORT;
          end
        end else begin
          res.status = ST_UNKNOWN;
        end
      end
    end
    res.legacy_mode     = mode_nxt;
    res.queue_not_empty = (count_nxt != '0);
  end

  // Control state of the framer and the queue.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r  <= '0;
      rptr_r  <= '0;
      wptr_r  <= '0;
      count_r <= '0;
      mode_r  <= 1'b0;
    end else if (in_acc) begin
      fill_r  <= fill_nxt;
      rptr_r  <= rptr_nxt;
      wptr_r  <= wptr_nxt;
      count_r <= count_nxt;
      mode_r  <= mode_nxt;
    end
  end

  // The first frame bytes are kept in registers for the dispatch decode.
  always_ff @(posedge clk) begin
    if (in_acc && in_operation == OP_BYTE) begin
      for (int i = 0; i < HEAD_BYTES; i++) begin
        if (fill_r == FILL_W'(i)) begin
          head_r[i] <= in_rx_byte;
        end
      end
    end
  end

  // Queue storage; a pop's byte comes from the registered read port.
  scf_ram #(
    .WIDTH (8),
    .DEPTH (QUEUE_DEPTH),
    .AW    (PTR_W)
  ) u_queue_ram (
    .clk   (clk),
    .we    (in_acc && push),
    .waddr (wptr_r),
    .wdata (fb[1]),
    .re    (in_acc && pop_hit),
    .raddr (rptr_r),
    .rdata (ram_rdata)
  );

  // First result stage, waiting on the RAM read.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= gen;
    end else if (s1_move) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_res_r <= res;
    end
  end

  // Output register; the popped byte is merged in here.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_move) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_res_r <= s1_res_r;
      if (s1_res_r.use_ram) begin
        out_res_r.data_byte <= ram_rdata;
      end
    end
  end

  assign out_valid           = out_valid_r;
  assign out_status          = out_res_r.status;
  assign out_axis_x          = out_res_r.axis_x;
  assign out_axis_y          = out_res_r.axis_y;
  assign out_axis_z          = out_res_r.axis_z;
  assign out_data_byte       = out_res_r.data_byte;
  assign out_legacy_mode     = out_res_r.legacy_mode;
  assign out_queue_not_empty = out_res_r.queue_not_empty;

endmodule

>>> test/tb_serial_command_framer_with_fifo.sv
module tb_serial_command_framer_with_fifo;
  import scf_pkg::*;

  localparam int FRAME_LEN = scf_pkg::FRAME_BYTES_DEF;
  localparam int QUEUE_LEN = scf_pkg::QUEUE_DEPTH_DEF;
  localparam int RANDOM_PER_PHASE = 280;
  localparam int HOLD_CYCLES = 150;

  // One result transaction as seen on the output ports.
  typedef struct packed {
    bit [2:0] status;
    bit [7:0] axis_x;
    bit [7:0] axis_y;
    bit [7:0] axis_z;
    bit [7:0] data_byte;
    bit       legacy_mode;
    bit       queue_not_empty;
  } reply_t;

  // Tracks the framer state and holds the replies still owed by the block.
  class command_tracker;
    bit [7:0]    move_limit = LIMIT_RESET;
    bit [7:0]    frame_buf[FRAME_LEN];
    int          frame_fill = 0;
    bit [7:0]    queued_bytes[$];
    bit          mode_flag = 1'b0;
    reply_t      pending_replies[$];
    int unsigned commands_seen = 0;
    int unsigned mismatches = 0;

    function bit [7:0] clip_axis(bit [7:0] value);
      return (value > move_limit) ? move_limit : value;
    endfunction

    // Apply one accepted input transaction and queue the reply it causes, if any.
    function void note_command(bit op, bit [7:0] value);
      reply_t r;
      r = '0;
      commands_seen++;
      if (op == OP_POP) begin
        if (queued_bytes.size() == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.status = ST_POPPED;
          r.data_byte = queued_bytes.pop_front();
        end
        r.legacy_mode = mode_flag;
        r.queue_not_empty = (queued_bytes.size() != 0);
        pending_replies.push_back(r);
        return;
      end
      frame_buf[frame_fill] = value;
      frame_fill++;
      if (value != CH_NEWLINE && value != CH_BANG && frame_fill < FRAME_LEN) return;

      // The frame is complete: dispatch on its first byte.
      if (frame_buf[0] == CH_LEGACY) begin
        mode_flag = 1'b1;
        r.data_byte = frame_buf[1];
        if (queued_bytes.size() >= QUEUE_LEN) begin
          r.status = ST_FULL;
        end else begin
          queued_bytes.push_back(frame_buf[1]);
          r.status = ST_QUEUED;
        end
      end else if (frame_buf[0] == CH_MOVE) begin
        mode_flag = 1'b0;
        if (frame_fill >= MOVE_MIN_LEN) begin
          r.status = ST_MOVE;
          r.axis_x = clip_axis(frame_buf[1]);
          r.axis_y = clip_axis(frame_buf[2]);
          r.axis_z = clip_axis(frame_buf[3]);
        end else begin
          r.status = ST_SHORT;
        end
      end else begin
        r.status = ST_UNKNOWN;
      end
      r.legacy_mode = mode_flag;
      r.queue_not_empty = (queued_bytes.size() != 0);
      pending_replies.push_back(r);
      frame_fill = 0;
    endfunction

    function void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        mismatches++;
      end
    endfunction

    // Compare one accepted result transaction with the oldest owed reply.
    function void check_reply(reply_t got);
      reply_t want;
      if (pending_replies.size() == 0) begin
        $error("status: expected no result, got %0d", got.status);
        mismatches++;
        return;
      end
      want = pending_replies.pop_front();
      check_field("status", 32'(want.status), 32'(got.status));
      check_field("axis_x", 32'(want.axis_x), 32'(got.axis_x));
      check_field("axis_y", 32'(want.axis_y), 32'(got.axis_y));
      check_field("axis_z", 32'(want.axis_z), 32'(got.axis_z));
      check_field("data_byte", 32'(want.data_byte), 32'(got.data_byte));
      check_field("legacy_mode", 32'(want.legacy_mode), 32'(got.legacy_mode));
      check_field("queue_not_empty", 32'(want.queue_not_empty),
                  32'(got.queue_not_empty));
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic       in_operation;
  logic [7:0] in_rx_byte;
  logic       out_valid;
  logic       out_stall;
  logic [2:0] out_status;
  logic [7:0] out_axis_x;
  logic [7:0] out_axis_y;
  logic [7:0] out_axis_z;
  logic [7:0] out_data_byte;
  logic       out_legacy_mode;
  logic       out_queue_not_empty;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [7:0] cfg_move_limit;

  command_tracker tracker = new();
  int idle_pct = 6;
  int stall_pct = 6;
  bit hold_request = 1'b0;
  int hold_left = 0;

  serial_command_framer_with_fifo dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_operation        (in_operation),
    .in_rx_byte          (in_rx_byte),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_status          (out_status),
    .out_axis_x          (out_axis_x),
    .out_axis_y          (out_axis_y),
    .out_axis_z          (out_axis_z),
    .out_data_byte       (out_data_byte),
    .out_legacy_mode     (out_legacy_mode),
    .out_queue_not_empty (out_queue_not_empty),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_move_limit      (cfg_move_limit)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Offer one input transaction, after a random gap, and wait until it is taken.
  task automatic send_cmd(input bit op, input bit [7:0] value);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_operation <= op;
    in_rx_byte <= value;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tracker.note_command(op, value);
  endtask

  // Wait until every owed reply has arrived and the pipeline has emptied.
  task automatic drain;
    in_valid <= 1'b0;
    while (tracker.pending_replies.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // Change the movement limit while the block is idle.
  task automatic write_limit(input bit [7:0] value);
    drain();
    cfg_valid <= 1'b1;
    cfg_move_limit <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    tracker.move_limit = value;
  endtask

  // Frame content: half uniform, the rest values around the limit and the extremes.
  function automatic bit [7:0] body_byte();
    case ($urandom_range(3))
      0: return tracker.move_limit + 8'($urandom_range(2)) - 8'd1;
      1: return $urandom_range(1) ? 8'hFF : 8'h00;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // One random command sequence: pops, well-formed frames, broken frames or noise.
  task automatic send_random_sequence;
    int kind;
    int body_len;
    bit [7:0] head;
    bit [7:0] filler;
    kind = $urandom_range(99);
    if (kind < 20) begin
      repeat ($urandom_range(1, 3)) send_cmd(OP_POP, 8'($urandom_range(255)));
      return;
    end
    if (kind < 23) begin
      // Flood the queue with legacy frames so that it overflows.
      repeat (QUEUE_LEN + 3) begin
        send_cmd(OP_BYTE, CH_LEGACY);
        send_cmd(OP_BYTE, body_byte());
        send_cmd(OP_BYTE, CH_NEWLINE);
      end
      return;
    end
    if (kind < 55) begin
      head = CH_MOVE;
      body_len = ($urandom_range(3) == 0) ? $urandom_range(0, 6) : 3;
    end else if (kind < 80) begin
      head = CH_LEGACY;
      body_len = $urandom_range(1, 3);
    end else begin
      head = 8'($urandom_range(255));
      body_len = $urandom_range(0, 9);
    end
    send_cmd(OP_BYTE, head);
    repeat (body_len) send_cmd(OP_BYTE, body_byte());
    if ($urandom_range(4) != 0) begin
      send_cmd(OP_BYTE, $urandom_range(1) ? CH_NEWLINE : CH_BANG);
    end else begin
      // No terminator: keep going until the buffer fills and dispatches.
      while (tracker.frame_fill != 0) begin
        filler = 8'($urandom_range(255));
        if (filler == CH_NEWLINE || filler == CH_BANG) filler = filler ^ 8'h80;
        send_cmd(OP_BYTE, filler);
      end
    end
  endtask

  task automatic run_random_phase;
    int unsigned target;
    target = tracker.commands_seen + RANDOM_PER_PHASE;
    while (tracker.commands_seen < target) send_random_sequence();
  endtask

  // Result side: check accepted transactions and drive a random stall.
  initial begin
    reply_t seen;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        seen.status = out_status;
        seen.axis_x = out_axis_x;
        seen.axis_y = out_axis_y;
        seen.axis_z = out_axis_z;
        seen.data_byte = out_data_byte;
        seen.legacy_mode = out_legacy_mode;
        seen.queue_not_empty = out_queue_not_empty;
        tracker.check_reply(seen);
      end
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // Stimulus and end of run.
  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_operation <= OP_BYTE;
    in_rx_byte <= 8'h00;
    cfg_valid <= 1'b0;
    cfg_move_limit <= LIMIT_RESET;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty pop, exact-length move, short move, queue and pop,
    // lone newline, full-buffer move and a legacy frame ended by its data byte.
    send_cmd(OP_POP, 8'hFF);
    send_cmd(OP_BYTE, CH_MOVE);
    send_cmd(OP_BYTE, 8'h00);
    send_cmd(OP_BYTE, 8'hFF);
    send_cmd(OP_BYTE, CH_NEWLINE);
    send_cmd(OP_BYTE, CH_MOVE);
    send_cmd(OP_BYTE, CH_BANG);
    send_cmd(OP_BYTE, CH_LEGACY);
    send_cmd(OP_BYTE, 8'hA5);
    send_cmd(OP_BYTE, CH_BANG);
    send_cmd(OP_POP, 8'h00);
    send_cmd(OP_BYTE, CH_NEWLINE);
    send_cmd(OP_BYTE, CH_MOVE);
    send_cmd(OP_BYTE, 8'h1A);
    send_cmd(OP_BYTE, 8'h80);
    send_cmd(OP_BYTE, 8'hFE);
    send_cmd(OP_BYTE, 8'h33);
    send_cmd(OP_BYTE, 8'h44);
    send_cmd(OP_BYTE, 8'h55);
    send_cmd(OP_BYTE, 8'h66);
    send_cmd(OP_BYTE, 8'h77);
    send_cmd(OP_BYTE, 8'h88);
    send_cmd(OP_BYTE, CH_LEGACY);
    send_cmd(OP_BYTE, CH_NEWLINE);
    send_cmd(OP_POP, 8'h5A);

    // Random phases under several limits, the extremes among them.
    run_random_phase();
    write_limit(8'd0);
    run_random_phase();
    write_limit(8'd255);
    idle_pct = 0;
    stall_pct = 0;
    run_random_phase();
    idle_pct = 6;
    stall_pct = 6;
    write_limit(8'($urandom_range(1, 254)));
    hold_request = 1'b1;
    run_random_phase();
    write_limit(8'($urandom_range(1, 254)));
    run_random_phase();

    drain();
    if (tracker.mismatches == 0 && tracker.pending_replies.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #400000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
